// ===== hdl/zar_pkg.sv =====
// Shared constants, types and helpers for the zone alarm relay controller.
package zar_pkg;

  localparam int NUM_ZONES_DEF  = 8;
  localparam int NUM_RELAYS_DEF = 4;

  localparam int MS_W = 18;

  localparam logic [2:0] ZM_DISARMED = 3'd0;
  localparam logic [2:0] ZM_ARMING   = 3'd1;
  localparam logic [2:0] ZM_ARMED    = 3'd2;
  localparam logic [2:0] ZM_ENTRY    = 3'd3;
  localparam logic [2:0] ZM_ALARM    = 3'd4;

  localparam logic [1:0] RM_OFF    = 2'd0;
  localparam logic [1:0] RM_ON     = 2'd1;
  localparam logic [1:0] RM_FOLLOW = 2'd2;
  localparam logic [1:0] RM_PULSE  = 2'd3;

  localparam logic [2:0] REG_ZONE_FLAGS  = 3'd0;
  localparam logic [2:0] REG_EXIT        = 3'd1;
  localparam logic [2:0] REG_ENTRY       = 3'd2;
  localparam logic [2:0] REG_SIREN_ON    = 3'd3;
  localparam logic [2:0] REG_SIREN_OFF   = 3'd4;
  localparam logic [2:0] REG_PULSE_ON    = 3'd5;
  localparam logic [2:0] REG_PULSE_OFF   = 3'd6;
  localparam logic [2:0] REG_RELAY_SETUP = 3'd7;

  localparam logic [MS_W-1:0] SETTLE_MS = 18'd500;

  typedef logic [MS_W-1:0] ms_t;

  // seconds to milliseconds, constant multiply
  function automatic ms_t secs_to_ms(input logic [7:0] secs);
    return ms_t'(secs) * ms_t'(1000);
  endfunction

endpackage

// ===== hdl/zar_elapsed.sv =====
// Shared elapsed-time unit: wrapped time difference compared with a limit.
module zar_elapsed (
  input  logic [31:0]      now,
  input  logic [31:0]      stamp,
  input  zar_pkg::ms_t     limit,
  output logic             reached
);

  logic [31:0] diff;

  assign diff    = now - stamp;
  assign reached = diff >= {14'd0, limit};

endmodule

// ===== hdl/zone_alarm_relay_controller.sv =====
// Zone alarm relay controller top level with sequencer and state stores.
//
// Usage: one transaction on the s_ channel is one tick: time in ms, zone trip,
// arm and disarm masks, relay override mask and level. Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this.
// Each tick is processed by a sequencer that visits one zone per cycle
// (arm/disarm, zone step, earliest-alarm search) and then one relay per
// cycle, all through one shared elapsed-time compare unit. After the walk
// the ST_DONE state loads the result register on the m_ channel, waiting
// there while the receiver still holds back an earlier result.
// s_tready is high only while the sequencer is idle. A finished result
// waits in the output register; a new tick may be accepted meanwhile, and
// its result is held back until the receiver has taken the earlier one.
// rst (synchronous) clears all zone and relay state and the config
// registers: zones disarmed, relays off.
module zone_alarm_relay_controller #(
  parameter int NUM_ZONES  = zar_pkg::NUM_ZONES_DEF,
  parameter int NUM_RELAYS = zar_pkg::NUM_RELAYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // now_ms[31:0], tripped_mask[39:32], arm_mask[47:40], disarm_mask[55:48],
  // override_mask[59:56], override_level[63:60]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // relay_levels[3:0], zone_states[27:4], alarm_mask[35:28], zero pad [39:36]
  output logic [39:0] m_tdata
);

  localparam int ZW = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
  localparam int RW = (NUM_RELAYS > 1) ? $clog2(NUM_RELAYS) : 1;
  localparam int CW = (ZW > RW) ? ZW : RW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ZONE  = 2'd1;
  localparam logic [1:0] ST_RELAY = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]  state;
  logic [CW-1:0] cnt;

  logic [23:0] zone_flags;
  logic [63:0] exit_delays, entry_delays, siren_on_times, siren_off_times;
  logic [63:0] pulse_on_times, pulse_off_times;
  logic [27:0] relay_setup;

  logic [31:0] now_q;
  logic [7:0]  trip_q, arm_q, disarm_q;
  logic [3:0]  ovr_q, lvl_q;

  logic [2:0]  zone_mode   [NUM_ZONES];
  logic [31:0] arm_stamp   [NUM_ZONES];
  logic [31:0] entry_stamp [NUM_ZONES];
  logic [31:0] alarm_stamp [NUM_ZONES];
  logic [31:0] relay_phase_stamp [NUM_RELAYS];
  logic [NUM_RELAYS-1:0] relay_pulse_high, relay_shot_done, relay_out;

  // earliest alarm search, group 1 siren, group 2 alarm relay
  logic        any1, any2;
  logic [31:0] old1, old2;
  logic [7:0]  on1, off1, on2, off2;

  // shared unit
  logic [31:0]  el_stamp;
  zar_pkg::ms_t el_limit;
  logic         el_reached;

  zar_elapsed u_elapsed (
    .now     (now_q),
    .stamp   (el_stamp),
    .limit   (el_limit),
    .reached (el_reached)
  );

  // zone step
  logic [ZW-1:0] zi;
  logic [2:0]    zs;
  logic          zen;
  logic [2:0]    mode_a, mode_n;
  logic [31:0]   astamp, arm_n, entry_n, alarm_n;
  logic [31:0]   z_stamp;
  zar_pkg::ms_t  z_limit;
  logic          q1, q2;

  assign zi  = cnt[ZW-1:0];
  assign zs  = 3'(zi);
  assign zen = zone_flags[{2'b00, zs}];

  always_comb begin
    mode_a  = zone_mode[zi];
    astamp  = arm_stamp[zi];
    if (disarm_q[zs]) begin
      mode_a = zar_pkg::ZM_DISARMED;
    end else if (arm_q[zs] && zen && zone_mode[zi] == zar_pkg::ZM_DISARMED) begin
      mode_a = zar_pkg::ZM_ARMING;
      astamp = now_q;
    end
    case (mode_a)
      zar_pkg::ZM_ARMING: begin
        z_stamp = astamp;
        z_limit = zar_pkg::secs_to_ms(exit_delays[{zs, 3'b000} +: 8]);
      end
      zar_pkg::ZM_ARMED: begin
        z_stamp = astamp;
        z_limit = zar_pkg::SETTLE_MS;
      end
      zar_pkg::ZM_ENTRY: begin
        z_stamp = entry_stamp[zi];
        z_limit = zar_pkg::secs_to_ms(entry_delays[{zs, 3'b000} +: 8]);
      end
      default: begin
        z_stamp = astamp;
        z_limit = '0;
      end
    endcase
    mode_n  = mode_a;
    arm_n   = astamp;
    entry_n = entry_stamp[zi];
    alarm_n = alarm_stamp[zi];
    if (zen) begin
      case (mode_a)
        zar_pkg::ZM_ARMING: begin
          if (el_reached) begin
            mode_n = zar_pkg::ZM_ARMED;
            arm_n  = now_q;
          end
        end
        zar_pkg::ZM_ARMED: begin
          if (el_reached && trip_q[zs]) begin
            if (entry_delays[{zs, 3'b000} +: 8] != 8'd0) begin
              mode_n  = zar_pkg::ZM_ENTRY;
              entry_n = now_q;
            end else begin
              mode_n  = zar_pkg::ZM_ALARM;
              alarm_n = now_q;
            end
          end
        end
        zar_pkg::ZM_ENTRY: begin
          if (el_reached) begin
            mode_n  = zar_pkg::ZM_ALARM;
            alarm_n = now_q;
          end
        end
        default: ;
      endcase
    end
    q1 = zen && zone_flags[{2'b01, zs}] && mode_n == zar_pkg::ZM_ALARM;
    q2 = zen && zone_flags[{2'b10, zs}] && mode_n == zar_pkg::ZM_ALARM;
  end

  // per-zone siren qualifier from settled zone state, for fixed-zone follow
  logic [7:0] siren_q;
  always_comb begin
    siren_q = '0;
    for (int z = 0; z < NUM_ZONES; z++) begin
      siren_q[z] = zone_flags[z] && zone_flags[8 + z] &&
                   zone_mode[z] == zar_pkg::ZM_ALARM;
    end
  end

  // relay step
  logic [RW-1:0] ri;
  logic [1:0]    rs;
  logic [6:0]    rcfg;
  logic [1:0]    rmode;
  logic [3:0]    zsel;
  logic [2:0]    fz;
  logic          r_any;
  logic [7:0]    r_on, r_off;
  logic [31:0]   pstamp, r_stamp;
  zar_pkg::ms_t  r_limit;
  logic          out_n, high_n, shot_n;
  logic [31:0]   pstamp_n;

  assign ri   = cnt[RW-1:0];
  assign rs   = 2'(ri);
  assign rcfg = relay_setup[{3'b000, rs} * 5'd7 +: 7];
  assign rmode = rcfg[2:1];
  assign zsel  = rcfg[6:3];
  assign fz    = 3'(zsel - 4'd1);
  assign pstamp = relay_phase_stamp[ri];

  always_comb begin
    r_any = 1'b0;
    r_on  = '0;
    r_off = '0;
    if (rmode == zar_pkg::RM_FOLLOW) begin
      if (zsel == 4'd0) begin
        r_any = any1;
        r_on  = on1;
        r_off = off1;
      end else if (zsel <= 4'(NUM_ZONES)) begin
        r_any = siren_q[fz];
        if (siren_q[fz]) begin
          r_on  = siren_on_times[{fz, 3'b000} +: 8];
          r_off = siren_off_times[{fz, 3'b000} +: 8];
        end
      end
    end else begin
      r_any = any2;
      r_on  = on2;
      r_off = off2;
    end
    r_stamp = (r_off == 8'd0 && pstamp == 32'd0) ? now_q : pstamp;
    r_limit = (r_off == 8'd0 || relay_pulse_high[ri]) ? zar_pkg::secs_to_ms(r_on)
                                                      : zar_pkg::secs_to_ms(r_off);
    out_n    = relay_out[ri];
    high_n   = relay_pulse_high[ri];
    shot_n   = relay_shot_done[ri];
    pstamp_n = pstamp;
    if (ovr_q[rs]) begin
      out_n = lvl_q[rs];
    end else if (!rcfg[0] || rmode == zar_pkg::RM_OFF) begin
      out_n = 1'b0;
    end else if (rmode == zar_pkg::RM_ON) begin
      out_n = 1'b1;
    end else if (!r_any) begin
      high_n   = 1'b0;
      pstamp_n = '0;
      shot_n   = 1'b0;
      out_n    = 1'b0;
    end else if (r_on == 8'd0) begin
      high_n   = 1'b0;
      pstamp_n = '0;
      out_n    = 1'b1;
    end else if (r_off == 8'd0) begin
      if (!relay_shot_done[ri]) begin
        pstamp_n = r_stamp;
        if (el_reached) begin
          high_n = 1'b0;
          shot_n = 1'b1;
          out_n  = 1'b0;
        end else begin
          out_n = 1'b1;
        end
      end
    end else begin
      if (relay_pulse_high[ri]) begin
        if (el_reached) begin
          high_n   = 1'b0;
          pstamp_n = now_q;
        end
      end else if (el_reached || pstamp == 32'd0) begin
        high_n   = 1'b1;
        pstamp_n = now_q;
      end
      out_n = high_n;
    end
  end

  assign el_stamp = (state == ST_RELAY) ? r_stamp : z_stamp;
  assign el_limit = (state == ST_RELAY) ? r_limit : z_limit;

  assign s_tready = (state == ST_IDLE);

  // result assembly
  logic [3:0]  levels;
  logic [23:0] states;
  logic [7:0]  alarms;
  always_comb begin
    levels = '0;
    states = '0;
    alarms = '0;
    for (int r = 0; r < NUM_RELAYS; r++) levels[r] = relay_out[r];
    for (int z = 0; z < NUM_ZONES; z++) begin
      states[3*z +: 3] = zone_mode[z];
      alarms[z]        = zone_mode[z] == zar_pkg::ZM_ALARM;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      zone_flags      <= '0;
      exit_delays     <= '0;
      entry_delays    <= '0;
      siren_on_times  <= '0;
      siren_off_times <= '0;
      pulse_on_times  <= '0;
      pulse_off_times <= '0;
      relay_setup     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        zar_pkg::REG_ZONE_FLAGS:  zone_flags      <= cfg_data[23:0];
        zar_pkg::REG_EXIT:        exit_delays     <= cfg_data;
        zar_pkg::REG_ENTRY:       entry_delays    <= cfg_data;
        zar_pkg::REG_SIREN_ON:    siren_on_times  <= cfg_data;
        zar_pkg::REG_SIREN_OFF:   siren_off_times <= cfg_data;
        zar_pkg::REG_PULSE_ON:    pulse_on_times  <= cfg_data;
        zar_pkg::REG_PULSE_OFF:   pulse_off_times <= cfg_data;
        zar_pkg::REG_RELAY_SETUP: relay_setup     <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  // sequencer and state stores
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      cnt              <= '0;
      m_tvalid         <= 1'b0;
      m_tdata          <= '0;
      relay_pulse_high <= '0;
      relay_shot_done  <= '0;
      relay_out        <= '0;
      for (int z = 0; z < NUM_ZONES; z++) begin
        zone_mode[z]   <= zar_pkg::ZM_DISARMED;
        arm_stamp[z]   <= '0;
        entry_stamp[z] <= '0;
        alarm_stamp[z] <= '0;
      end
      for (int r = 0; r < NUM_RELAYS; r++) relay_phase_stamp[r] <= '0;
    end else begin
      // ST_DONE reloads the output register itself
      if (m_tvalid && m_tready && state != ST_DONE) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            now_q    <= s_tdata[31:0];
            trip_q   <= s_tdata[39:32];
            arm_q    <= s_tdata[47:40];
            disarm_q <= s_tdata[55:48];
            ovr_q    <= s_tdata[59:56];
            lvl_q    <= s_tdata[63:60];
            any1 <= 1'b0;
            any2 <= 1'b0;
            old1 <= '1;
            old2 <= '1;
            on1  <= '0;
            off1 <= '0;
            on2  <= '0;
            off2 <= '0;
            cnt   <= '0;
            state <= ST_ZONE;
          end
        end
        ST_ZONE: begin
          zone_mode[zi]   <= mode_n;
          arm_stamp[zi]   <= arm_n;
          entry_stamp[zi] <= entry_n;
          alarm_stamp[zi] <= alarm_n;
          if (q1) begin
            any1 <= 1'b1;
            if (alarm_n < old1) begin
              old1 <= alarm_n;
              on1  <= siren_on_times[{zs, 3'b000} +: 8];
              off1 <= siren_off_times[{zs, 3'b000} +: 8];
            end
          end
          if (q2) begin
            any2 <= 1'b1;
            if (alarm_n < old2) begin
              old2 <= alarm_n;
              on2  <= pulse_on_times[{zs, 3'b000} +: 8];
              off2 <= pulse_off_times[{zs, 3'b000} +: 8];
            end
          end
          if (cnt == CW'(NUM_ZONES - 1)) begin
            cnt   <= '0;
            state <= ST_RELAY;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_RELAY: begin
          relay_out[ri]         <= out_n;
          relay_pulse_high[ri]  <= high_n;
          relay_shot_done[ri]   <= shot_n;
          relay_phase_stamp[ri] <= pstamp_n;
          if (cnt == CW'(NUM_RELAYS - 1)) begin
            cnt   <= '0;
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {4'd0, alarms, states, levels};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/zar_checker.sv =====
// Port-level assertions for the zone alarm relay controller, with bind.
module zar_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // a result waiting on the receiver stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // the block is busy walking zones right after taking a tick
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken twice in a row");

  // a new result only appears when the sequencer finishes its walk
  a_result_after_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result without a finished walk");

  // alarm bit of zone 1 agrees with its state field
  a_alarm_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[28] == (m_tdata[6:4] == zar_pkg::ZM_ALARM)))
    else $error("alarm bit and zone state disagree");

  // zone 1 state code stays in the defined range
  a_state_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[6:4] <= zar_pkg::ZM_ALARM))
    else $error("zone state out of range");

endmodule

bind zone_alarm_relay_controller zar_checker u_zar_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the zone alarm relay controller.
module testbench;

  typedef struct packed {
    logic [7:0]  alarms;
    logic [23:0] states;
    logic [3:0]  levels;
  } tick_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  zone_alarm_relay_controller u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copies
  logic [63:0] zone_flags, exit_delays, entry_delays, siren_on, siren_off;
  logic [63:0] pulse_on, pulse_off, relay_setup;
  // zone and relay state of the predictor
  logic [2:0]  zmode[8];
  logic [31:0] arm_ts[8], entry_ts[8], alarm_ts[8], phase_ts[4];
  bit          pulse_hi[4], shot_done[4], rly_lvl[4];

  tick_result_t expected_ticks[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   rx_hold = 0;
  bit   quiet = 1'b0;
  logic [31:0] now_t = '0;

  function automatic logic [31:0] secs(logic [63:0] r, int z);
    return {24'd0, r[8*z +: 8]};
  endfunction

  function automatic bit zflag(int grp, int z);
    return zone_flags[8*grp + z];
  endfunction

  function automatic bit earliest_alarm(int grp, logic [63:0] on_reg, logic [63:0] off_reg,
                                        output logic [31:0] on_s, output logic [31:0] off_s);
    bit any;
    logic [31:0] oldest;
    any = 1'b0;
    oldest = 32'hFFFF_FFFF;
    on_s = '0;
    off_s = '0;
    for (int z = 0; z < 8; z++) begin
      if (zflag(0, z) && zflag(grp, z) && zmode[z] == zar_pkg::ZM_ALARM) begin
        any = 1'b1;
        if (alarm_ts[z] < oldest) begin
          oldest = alarm_ts[z];
          on_s = secs(on_reg, z);
          off_s = secs(off_reg, z);
        end
      end
    end
    return any;
  endfunction

  function automatic void run_relay_timer(int r, bit any, logic [31:0] on_s,
                                          logic [31:0] off_s, logic [31:0] now);
    if (!any) begin
      pulse_hi[r] = 1'b0; phase_ts[r] = '0; shot_done[r] = 1'b0; rly_lvl[r] = 1'b0;
    end else if (on_s == 0) begin
      pulse_hi[r] = 1'b0; phase_ts[r] = '0; rly_lvl[r] = 1'b1;
    end else if (off_s == 0) begin
      // one-shot: level frozen once done
      if (!shot_done[r]) begin
        if (phase_ts[r] == 0) phase_ts[r] = now;
        if (now - phase_ts[r] >= on_s * 32'd1000) begin
          pulse_hi[r] = 1'b0; shot_done[r] = 1'b1; rly_lvl[r] = 1'b0;
        end else begin
          rly_lvl[r] = 1'b1;
        end
      end
    end else begin
      if (pulse_hi[r]) begin
        if (now - phase_ts[r] >= on_s * 32'd1000) begin
          pulse_hi[r] = 1'b0; phase_ts[r] = now;
        end
      end else if (now - phase_ts[r] >= off_s * 32'd1000 || phase_ts[r] == 0) begin
        pulse_hi[r] = 1'b1; phase_ts[r] = now;
      end
      rly_lvl[r] = pulse_hi[r];
    end
  endfunction

  function automatic void drive_relay(int r, logic [31:0] now);
    logic [6:0]  rcfg;
    logic [1:0]  mode;
    logic [3:0]  zsel;
    logic [31:0] on_s, off_s;
    bit          any;
    rcfg = relay_setup[7*r +: 7];
    mode = rcfg[2:1];
    zsel = rcfg[6:3];
    on_s = '0;
    off_s = '0;
    any = 1'b0;
    if (!rcfg[0] || mode == zar_pkg::RM_OFF) begin
      rly_lvl[r] = 1'b0;
      return;
    end
    if (mode == zar_pkg::RM_ON) begin
      rly_lvl[r] = 1'b1;
      return;
    end
    if (mode == zar_pkg::RM_FOLLOW) begin
      if (zsel == 0) begin
        any = earliest_alarm(1, siren_on, siren_off, on_s, off_s);
      end else if (zsel <= 8) begin
        if (zflag(0, zsel - 1) && zflag(1, zsel - 1) &&
            zmode[zsel - 1] == zar_pkg::ZM_ALARM) begin
          any = 1'b1;
          on_s = secs(siren_on, zsel - 1);
          off_s = secs(siren_off, zsel - 1);
        end
      end
    end else begin
      any = earliest_alarm(2, pulse_on, pulse_off, on_s, off_s);
    end
    run_relay_timer(r, any, on_s, off_s, now);
  endfunction

  function automatic tick_result_t predict_tick(logic [63:0] d);
    logic [31:0] now;
    tick_result_t res;
    now = d[31:0];
    res = '0;
    for (int z = 0; z < 8; z++) begin
      if (d[48 + z]) zmode[z] = zar_pkg::ZM_DISARMED;
      else if (d[40 + z] && zflag(0, z) && zmode[z] == zar_pkg::ZM_DISARMED) begin
        zmode[z] = zar_pkg::ZM_ARMING;
        arm_ts[z] = now;
      end
    end
    for (int z = 0; z < 8; z++) begin
      if (zflag(0, z)) begin
        case (zmode[z])
          zar_pkg::ZM_ARMING: if (now - arm_ts[z] >= secs(exit_delays, z) * 32'd1000) begin
            zmode[z] = zar_pkg::ZM_ARMED;
            arm_ts[z] = now;
          end
          zar_pkg::ZM_ARMED: if (now - arm_ts[z] >= 32'd500 && d[32 + z]) begin
            if (secs(entry_delays, z) > 0) begin
              zmode[z] = zar_pkg::ZM_ENTRY;
              entry_ts[z] = now;
            end else begin
              zmode[z] = zar_pkg::ZM_ALARM;
              alarm_ts[z] = now;
            end
          end
          zar_pkg::ZM_ENTRY: if (now - entry_ts[z] >= secs(entry_delays, z) * 32'd1000) begin
            zmode[z] = zar_pkg::ZM_ALARM;
            alarm_ts[z] = now;
          end
          default: ;
        endcase
      end
    end
    for (int r = 0; r < 4; r++) begin
      if (d[56 + r]) rly_lvl[r] = d[60 + r];
      else drive_relay(r, now);
      res.levels[r] = rly_lvl[r];
    end
    for (int z = 0; z < 8; z++) begin
      res.states[3*z +: 3] = zmode[z];
      res.alarms[z] = (zmode[z] == zar_pkg::ZM_ALARM);
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic write_register(logic [2:0] idx, logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      zar_pkg::REG_ZONE_FLAGS:  zone_flags = value & 64'hFF_FFFF;
      zar_pkg::REG_EXIT:        exit_delays = value;
      zar_pkg::REG_ENTRY:       entry_delays = value;
      zar_pkg::REG_SIREN_ON:    siren_on = value;
      zar_pkg::REG_SIREN_OFF:   siren_off = value;
      zar_pkg::REG_PULSE_ON:    pulse_on = value;
      zar_pkg::REG_PULSE_OFF:   pulse_off = value;
      zar_pkg::REG_RELAY_SETUP: relay_setup = value & 64'hFFF_FFFF;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_tick(logic [31:0] now, logic [7:0] trip, logic [7:0] arm,
                           logic [7:0] disarm, logic [3:0] ovr, logic [3:0] lvl);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {lvl, ovr, disarm, arm, trip, now};
    do @(posedge clk); while (!s_tready);
    expected_ticks.push_back(predict_tick({lvl, ovr, disarm, arm, trip, now}));
  endtask

  // hold off until every result is back, then let the sequencer settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      rx_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    tick_result_t exp_r, got;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[35:0];
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %h", m_tdata);
      end else begin
        exp_r = expected_ticks.pop_front();
        if (got.levels !== exp_r.levels || got.states !== exp_r.states ||
            got.alarms !== exp_r.alarms) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected relays %h states %h alarms %h, got %h %h %h",
                     exp_r.levels, exp_r.states, exp_r.alarms,
                     got.levels, got.states, got.alarms);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == 3000) begin
      $display("zone_alarm_relay_controller: mismatch");
      $finish;
    end
  end

  // zero config: overrides only, arm ignored on disabled zones
  task automatic test_reset_config();
    send_tick(32'd0, 8'hFF, 8'hFF, 8'h00, 4'h0, 4'h0);
    send_tick(32'd100, 8'hFF, 8'h00, 8'h00, 4'hF, 4'hF);
    send_tick(32'd200, 8'h00, 8'h00, 8'h00, 4'hF, 4'h0);
    send_tick(32'd300, 8'h00, 8'h00, 8'hFF, 4'h5, 4'hA);
    drain();
  endtask

  task automatic test_directed();
    write_register(zar_pkg::REG_ZONE_FLAGS, 64'hFF_FFFF);
    write_register(zar_pkg::REG_EXIT, 64'hFF00_0000_0000_0100);
    write_register(zar_pkg::REG_ENTRY, 64'h0000_0000_0000_0200);
    write_register(zar_pkg::REG_SIREN_ON, 64'h0000_0000_0000_0102);
    write_register(zar_pkg::REG_SIREN_OFF, 64'h0000_0000_0000_0001);
    write_register(zar_pkg::REG_PULSE_ON, 64'h0000_0000_0000_0201);
    write_register(zar_pkg::REG_PULSE_OFF, 64'h0000_0000_0000_0000);
    // relay 1 follow earliest, relay 2 pulse, relay 3 follow zone 15, relay 4 on
    write_register(zar_pkg::REG_RELAY_SETUP,
                   64'({zar_pkg::RM_ON, 1'b1, 4'd15, zar_pkg::RM_FOLLOW, 1'b1,
                        4'd0, zar_pkg::RM_PULSE, 1'b1, 4'd0, zar_pkg::RM_FOLLOW, 1'b1}));
    send_tick(32'd0, 8'h00, 8'hFF, 8'h00, 4'h0, 4'h0);
    send_tick(32'd0, 8'hFF, 8'h00, 8'h00, 4'h0, 4'h0);
    send_tick(32'd400, 8'hFF, 8'h00, 8'h00, 4'h0, 4'h0);
    send_tick(32'd600, 8'hFF, 8'h00, 8'h00, 4'h0, 4'h0);
    send_tick(32'd1000, 8'hFF, 8'h00, 8'h00, 4'h0, 4'h0);
    send_tick(32'd1600, 8'hFF, 8'h00, 8'h00, 4'h0, 4'h0);
    for (int i = 0; i < 8; i++)
      send_tick(32'(2000 + 600 * i), 8'h00, 8'h00, 8'h00, 4'h0, 4'h0);
    send_tick(32'd8000, 8'h00, 8'hFF, 8'hFF, 4'h0, 4'h0);
    send_tick(32'd8100, 8'hFF, 8'hFF, 8'h00, 4'h0, 4'h0);
    send_tick(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'hF);
    send_tick(32'd10, 8'hFF, 8'hFF, 8'h00, 4'hF, 4'h0);
    drain();
  endtask

  function automatic logic [63:0] rand_secs();
    logic [63:0] v;
    for (int z = 0; z < 8; z++)
      v[8*z +: 8] = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3))
                                               : 8'($urandom_range(0, 255));
    return v;
  endfunction

  task automatic test_random_phase(int phase, int count);
    logic [7:0] trip, arm, disarm;
    logic [3:0] ovr, lvl;
    int r;
    quiet = (phase % 3 == 2);
    if (phase == 0) begin
      for (int i = 0; i < 8; i++) write_register(i[2:0], '1);
    end else if (phase == 1) begin
      for (int i = 1; i < 7; i++) write_register(i[2:0], '0);
      write_register(zar_pkg::REG_ZONE_FLAGS, 64'hFF_FFFF);
      write_register(zar_pkg::REG_RELAY_SETUP, {$urandom, $urandom});
    end else begin
      write_register(zar_pkg::REG_ZONE_FLAGS, {$urandom, $urandom} | 64'hFF);
      write_register(zar_pkg::REG_EXIT, rand_secs());
      write_register(zar_pkg::REG_ENTRY, rand_secs());
      write_register(zar_pkg::REG_SIREN_ON, rand_secs());
      write_register(zar_pkg::REG_SIREN_OFF, rand_secs());
      write_register(zar_pkg::REG_PULSE_ON, rand_secs());
      write_register(zar_pkg::REG_PULSE_OFF, rand_secs());
      write_register(zar_pkg::REG_RELAY_SETUP, {$urandom, $urandom});
    end
    if (phase == 3) now_t = 32'hFFFF_F000;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_tick($urandom, 8'($urandom), 8'($urandom), 8'($urandom),
                  4'($urandom), 4'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        now_t += (r < 90) ? 32'd100 : (r < 96) ? $urandom_range(0, 5000) : $urandom;
        trip = ($urandom_range(0, 9) < 3) ? 8'($urandom) : 8'h00;
        arm = ($urandom_range(0, 9) < 1) ? 8'($urandom) : 8'h00;
        disarm = ($urandom_range(0, 99) < 3) ? 8'($urandom) : 8'h00;
        ovr = ($urandom_range(0, 9) < 1) ? 4'($urandom) : 4'h0;
        lvl = 4'($urandom);
        send_tick(now_t, trip, arm, disarm, ovr, lvl);
      end
      if ($urandom_range(0, 99) < 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_config();
    test_directed();
    for (int p = 0; p < 7; p++) test_random_phase(p, 140);
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("zone_alarm_relay_controller: match");
    end else begin
      $display("zone_alarm_relay_controller: mismatch");
    end
    $finish;
  end

endmodule
